// ===== design/cqss_pkg.sv =====
// Shared constants, codes and types of the circular queue with search and sort.
package cqss_pkg;

  localparam int DEPTH     = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int OP_W      = 3;
  localparam int STAT_W    = 2;
  localparam int CAP_W     = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_SEARCH = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_SORT   = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_UNDERFLOW = 2'd1,
    STAT_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_TAKE_RIGHT,
    CELL_TAKE_LEFT,
    CELL_TAKE_HEAD
  } cell_act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SORT
  } state_e;

  typedef struct packed {
    logic             search;
    logic             sort;
    logic [IDX_W-1:0] step;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic                 start_search;
    logic                 start_sort;
    logic [CNT_W-1:0]     count;
  } start_t;

endpackage

// ===== design/circular_queue_search_sort.sv =====
// Signed-word FIFO with settable capacity; search and in-place ascending sort.
// Push, pop, peek, clear and undefined codes complete on acceptance: the next word
// is accepted in the following cycle unless the result is stalled, and the result
// appears in the cycle after acceptance. Search and sort hold the input off during
// a pass (sort runs no pass when the queue holds at most one word, search none when empty):
// the entries sit in a chain of cells ordered from the head, a search rotates
// them once through the head cell where the key is compared, and a sort runs
// one odd-even compare-and-swap phase per stored word across neighbor pairs.
// The result register decouples the sides: a new word is taken while the
// previous result drains. Writing the capacity register empties the queue;
// a capacity of zero acts as one, and values above the depth act as the depth.
module circular_queue_search_sort (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cqss_pkg::OP_W-1:0]       op_i,
  input  logic signed [cqss_pkg::WORD_BITS-1:0] value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [cqss_pkg::WORD_BITS-1:0] data_o,
  output logic                            found_o,
  output logic [cqss_pkg::IDX_W-1:0]      position_o,
  output logic [cqss_pkg::STAT_W-1:0]     status_o,
  output logic [cqss_pkg::CNT_W-1:0]      occupancy_o,
  output logic                            empty_res_o,
  output logic                            full_res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cqss_pkg::CAP_W-1:0]      cfg_data_i
);
  import cqss_pkg::*;

  typedef struct packed {
    logic [WORD_BITS-1:0] data;
    logic                 found;
    logic [IDX_W-1:0]     position;
    status_e              status;
    logic [CNT_W-1:0]     occupancy;
    logic                 empty;
    logic                 full;
  } result_t;

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     cap_q, cap_d;
  logic [WORD_BITS-1:0] key_q;
  logic                 found_q, found_d;
  logic [IDX_W-1:0]     pos_q, pos_d;
  logic                 out_valid_q;
  result_t              res_q, res_d;
  logic                 res_load;

  logic                 cfg_fire, accept_in, busy, full, nonempty, head_match;
  op_e                  op;
  start_t               start;
  ctrl_t                ctrl;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic                 gt        [DEPTH];
  logic                 swap      [DEPTH];
  cell_act_e            cell_act  [DEPTH];

  assign op         = op_e'(op_i);
  assign cfg_ready_o = 1'b1;
  assign cfg_fire   = cfg_valid_i && cfg_ready_o;
  assign busy       = ctrl.search || ctrl.sort;
  assign in_ready_o = !busy && (!out_valid_q || out_ready_i);
  assign accept_in  = in_valid_i && in_ready_o;
  assign full       = (count_q >= cap_q);
  assign nonempty   = (count_q != '0);
  assign head_match = (cell_word[0] == key_q);

  assign start.start_search = accept_in && (op == OP_SEARCH) && nonempty;
  assign start.start_sort   = accept_in && (op == OP_SORT) && (count_q > CNT_W'(1));
  assign start.count        = count_q;

  cqss_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .ctrl_o  (ctrl)
  );

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    localparam logic KODD = (k % 2) == 1;
    logic [WORD_BITS-1:0] right_word, left_word;
    logic                 swap_left;

    if (k < DEPTH - 1) begin : g_right
      assign right_word = cell_word[k+1];
      // swap this pair when it is in the current phase and out of order
      assign swap[k] = ctrl.sort && (KODD == ctrl.step[0]) &&
                       (CNT_W'(k + 1) < count_q) && gt[k];
    end else begin : g_edge_right
      assign right_word = '0;
      assign swap[k]    = 1'b0;
    end

    if (k > 0) begin : g_left
      assign left_word = cell_word[k-1];
      assign swap_left = swap[k-1];
    end else begin : g_edge_left
      assign left_word = '0;
      assign swap_left = 1'b0;
    end

    always_comb begin
      cell_act[k] = CELL_HOLD;
      if (accept_in && (op == OP_PUSH) && !full && (CNT_W'(k) == count_q)) begin
        cell_act[k] = CELL_LOAD;
      end else if (accept_in && (op == OP_POP) && nonempty) begin
        cell_act[k] = CELL_TAKE_RIGHT;
      end else if (ctrl.search) begin
        // rotate the stored words one place toward the head
        if (CNT_W'(k + 1) < count_q) begin
          cell_act[k] = CELL_TAKE_RIGHT;
        end else if (CNT_W'(k + 1) == count_q) begin
          cell_act[k] = CELL_TAKE_HEAD;
        end
      end else if (swap[k]) begin
        cell_act[k] = CELL_TAKE_RIGHT;
      end else if (swap_left) begin
        cell_act[k] = CELL_TAKE_LEFT;
      end
    end

    cqss_cell u_cell (
      .clk_i        (clk_i),
      .act_i        (cell_act[k]),
      .in_word_i    (value_i),
      .right_word_i (right_word),
      .left_word_i  (left_word),
      .head_word_i  (cell_word[0]),
      .word_o       (cell_word[k]),
      .gt_right_o   (gt[k])
    );
  end

  always_comb begin
    cap_d = cap_q;
    if (cfg_fire) begin
      if (cfg_data_i == '0) begin
        cap_d = CNT_W'(1);
      end else if ({{CNT_W{1'b0}}, cfg_data_i} > (CNT_W + CAP_W)'(DEPTH)) begin
        cap_d = CNT_W'(DEPTH);
      end else begin
        cap_d = CNT_W'(cfg_data_i);
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cfg_fire) begin
      count_d = '0;
    end else if (accept_in) begin
      case (op)
        OP_PUSH:  if (!full) count_d = count_q + CNT_W'(1);
        OP_POP:   if (nonempty) count_d = count_q - CNT_W'(1);
        OP_CLEAR: count_d = '0;
        default:  count_d = count_q;
      endcase
    end
  end

  // track the first hit while the words pass the head cell
  always_comb begin
    found_d = found_q;
    pos_d   = pos_q;
    if (start.start_search) begin
      found_d = 1'b0;
      pos_d   = '0;
    end else if (ctrl.search && head_match && !found_q) begin
      found_d = 1'b1;
      pos_d   = ctrl.step;
    end
  end

  always_comb begin
    res_d           = '0;
    res_d.status    = STAT_OK;
    res_d.occupancy = count_d;
    res_d.empty     = (count_d == '0);
    res_d.full      = (count_d == cap_q);
    res_load        = 1'b0;
    if (ctrl.last) begin
      res_load = 1'b1;
      if (ctrl.search) begin
        res_d.found = found_q || head_match;
        if (found_q) begin
          res_d.position = pos_q;
        end else if (head_match) begin
          res_d.position = ctrl.step;
        end
      end
    end else if (accept_in && !start.start_search && !start.start_sort) begin
      res_load = 1'b1;
      case (op)
        OP_PUSH: if (full) res_d.status = STAT_OVERFLOW;
        OP_POP, OP_PEEK: begin
          if (nonempty) begin
            res_d.data = cell_word[0];
          end else begin
            res_d.status = STAT_UNDERFLOW;
          end
        end
        default: res_d.status = STAT_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cap_q       <= CNT_W'(DEPTH);
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      pos_q       <= '0;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
      found_q <= found_d;
      pos_q   <= pos_d;
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      key_q <= value_i;
    end
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = res_q.data;
  assign found_o     = res_q.found;
  assign position_o  = res_q.position;
  assign status_o    = res_q.status;
  assign occupancy_o = res_q.occupancy;
  assign empty_res_o = res_q.empty;
  assign full_res_o  = res_q.full;

`ifndef NO_ASSERTIONS
  a_count_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("occupancy above capacity");

  a_pass_ends_in_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.last |=> out_valid_o)
    else $error("search or sort finished without a result");

  a_count_held_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && !cfg_fire) |=> (count_q == $past(count_q)))
    else $error("occupancy changed during search or sort");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && out_valid_q) |-> out_ready_i)
    else $error("pending result overwritten");
`endif

endmodule

// ===== design/cqss_cell.sv =====
// One queue entry of the cell chain: holds a word, trades it with its neighbors.
module cqss_cell (
  input  logic                            clk_i,
  input  cqss_pkg::cell_act_e             act_i,
  input  logic [cqss_pkg::WORD_BITS-1:0]  in_word_i,
  input  logic [cqss_pkg::WORD_BITS-1:0]  right_word_i,
  input  logic [cqss_pkg::WORD_BITS-1:0]  left_word_i,
  input  logic [cqss_pkg::WORD_BITS-1:0]  head_word_i,
  output logic [cqss_pkg::WORD_BITS-1:0]  word_o,
  output logic                            gt_right_o
);
  import cqss_pkg::*;

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    case (act_i)
      CELL_LOAD:       word_d = in_word_i;
      CELL_TAKE_RIGHT: word_d = right_word_i;
      CELL_TAKE_LEFT:  word_d = left_word_i;
      CELL_TAKE_HEAD:  word_d = head_word_i;
      default:         word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o     = word_q;
  assign gt_right_o = $signed(word_q) > $signed(right_word_i);

endmodule

// ===== design/cqss_ctrl.sv =====
// Sequencer for the multi-cycle search and sort passes over the cell chain.
module cqss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cqss_pkg::start_t start_i,
  output cqss_pkg::ctrl_t  ctrl_o
);
  import cqss_pkg::*;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] step_q, step_d;
  logic             last;

  // last step of a pass: one rotation or one sort phase per stored word
  assign last = (step_q == IDX_W'(start_i.count - CNT_W'(1)));

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = '0;
        if (start_i.start_search) begin
          state_d = ST_SEARCH;
        end else if (start_i.start_sort) begin
          state_d = ST_SORT;
        end
      end
      ST_SEARCH, ST_SORT: begin
        step_d = step_q + IDX_W'(1);
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o.search = (state_q == ST_SEARCH);
    ctrl_o.sort   = (state_q == ST_SORT);
    ctrl_o.step   = step_q;
    ctrl_o.last   = last && (state_q != ST_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
